FILE: design/mkc_pkg.sv
// Package for the magnitude keep-and-cap block.
// Holds default sizes, register indexes and the controller/datapath struct types.
// No dependencies.
package mkc_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_KEEP_ENABLE = 2'd0;
   localparam logic [1:0] REG_KEEP_COUNT  = 2'd1;
   localparam logic [1:0] REG_CAP_VALUE   = 2'd2;

   localparam logic [6:0]  KEEP_COUNT_RST = 7'd64;
   localparam logic [30:0] CAP_VALUE_RST  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic        keep_enable;
      logic [6:0]  keep_count;
      logic [30:0] cap_value;
   } cfg_type;

   typedef struct packed {
      logic store;      // write accepted sample at the fill count
      logic start;      // snapshot error/zeroing flags, clear entry index
      logic rd_i;       // read port addresses the current entry
      logic latch_v;    // capture current entry and its magnitude
      logic clr_sweep;  // clear rank and sweep index
      logic issue_j;    // read sweep entry, advance sweep index
      logic load_out;   // compute and register the result
      logic next_i;     // advance to the next entry
      logic finish;     // drop the fill count, run is done
   } cmd_type;

   typedef struct packed {
      logic zeroing;
      logic j_last;
      logic i_last;
   } stat_type;

endpackage

FILE: design/mkc_regs.sv
// Configuration register file, APB-style slave.
// Depends on mkc_pkg for register indexes, reset values and cfg_type.
module mkc_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mkc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mkc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mkc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output mkc_pkg::cfg_type               cfg
);
   import mkc_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keep_enable <= 1'b1;
         cfg_ff.keep_count  <= KEEP_COUNT_RST;
         cfg_ff.cap_value   <= CAP_VALUE_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_KEEP_ENABLE: cfg_ff.keep_enable <= csr_pwdata[0];
            REG_KEEP_COUNT:  cfg_ff.keep_count  <= csr_pwdata[6:0];
            REG_CAP_VALUE:   cfg_ff.cap_value   <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEEP_ENABLE: csr_prdata = {31'd0, cfg_ff.keep_enable};
         REG_KEEP_COUNT:  csr_prdata = {25'd0, cfg_ff.keep_count};
         REG_CAP_VALUE:   csr_prdata = {1'b0, cfg_ff.cap_value};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

FILE: design/mkc_ctrl.sv
// Controller state machine: load phase, per-entry rank sweep and result handoff.
// Depends on mkc_pkg for cmd_type and stat_type.
module mkc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  mkc_pkg::stat_type stat,
   output mkc_pkg::cmd_type  cmd
);
   import mkc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RD_I,
      ST_CAP_I,
      ST_SWEEP,
      ST_DRAIN,
      ST_RESULT,
      ST_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_tvalid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tlast) state_ff <= ST_START;
            end
            ST_START:  state_ff <= ST_RD_I;
            ST_RD_I:   state_ff <= ST_CAP_I;
            ST_CAP_I:  state_ff <= stat.zeroing ? ST_SWEEP : ST_RESULT;
            ST_SWEEP: begin
               if (stat.j_last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN:  state_ff <= ST_RESULT;
            ST_RESULT: begin
               state_ff      <= ST_HOLD;
               rsp_tvalid_ff <= 1'b1;
            end
            ST_HOLD: begin
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  state_ff      <= stat.i_last ? ST_IDLE : ST_RD_I;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.store     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.start     = (state_ff == ST_START);
      cmd.rd_i      = (state_ff == ST_RD_I);
      cmd.latch_v   = (state_ff == ST_CAP_I);
      cmd.clr_sweep = (state_ff == ST_CAP_I);
      cmd.issue_j   = (state_ff == ST_SWEEP);
      cmd.load_out  = (state_ff == ST_RESULT);
      cmd.next_i    = (state_ff == ST_HOLD) && rsp_tready && !stat.i_last;
      cmd.finish    = (state_ff == ST_HOLD) && rsp_tready && stat.i_last;
   end

endmodule

FILE: design/mkc_dpath.sv
// Datapath: entry memory, fill count, rank counter, zeroing and capping.
// Depends on mkc_pkg for cfg_type, cmd_type and stat_type.
module mkc_dpath #(
   parameter int MAX_ENTRIES = mkc_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_BITS  = mkc_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mkc_pkg::cfg_type      cfg,
   input  mkc_pkg::cmd_type      cmd,
   output mkc_pkg::stat_type     stat,
   input  logic [VALUE_BITS-1:0] req_sample,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic [5:0]            rsp_pos,
   output logic                  rsp_last,
   output logic                  rsp_err
);
   import mkc_pkg::*;

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CW     = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

   logic [VALUE_BITS-1:0] mem_ff [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     i_ff, i_in;
   logic [ADDR_W-1:0]     j_ff, j_in;
   logic [ADDR_W-1:0]     jd_ff;
   logic                  cmp_en_ff;
   logic [CNT_W-1:0]      rank_ff, rank_in;
   logic                  err_ff, zero_ff;
   logic [VALUE_BITS-1:0] v_ff;
   logic [VALUE_BITS-1:0] vmag_ff;
   logic [VALUE_BITS-1:0] rd_mag;
   logic                  outranks;
   logic                  full;
   logic                  err_now;

   logic                  zeroed;
   logic [CW-1:0]         kept_mag;
   logic [CW-1:0]         cap_x;
   logic [VALUE_BITS-1:0] result;

   logic [VALUE_BITS-1:0] out_value_ff;
   logic [5:0]            out_pos_ff;
   logic                  out_last_ff;
   logic                  out_err_ff;

   assign full    = (count_ff == FULL_CNT);
   assign rd_addr = cmd.rd_i ? i_ff : j_ff;
   assign err_now = cfg.keep_enable && (cfg.keep_count > 7'(count_ff));

   // Two's complement magnitude; the most negative value maps to 2^(VALUE_BITS-1).
   assign rd_mag  = rd_data_ff[VALUE_BITS-1] ? (VALUE_BITS'(0) - rd_data_ff) : rd_data_ff;

   // Larger magnitude ranks first; equal magnitudes rank the lower index first.
   assign outranks = (rd_mag > vmag_ff) || ((rd_mag == vmag_ff) && (jd_ff < i_ff));

   assign stat.zeroing = zero_ff;
   assign stat.j_last  = ((CNT_W'(j_ff) + CNT_W'(1)) == count_ff);
   assign stat.i_last  = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (cmd.store && !full) mem_ff[count_ff[ADDR_W-1:0]] <= req_sample;
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish) count_in = '0;
      else if (cmd.store && !full) count_in = count_ff + CNT_W'(1);

      i_in = i_ff;
      if (cmd.start) i_in = '0;
      else if (cmd.next_i) i_in = i_ff + ADDR_W'(1);

      j_in = j_ff;
      if (cmd.clr_sweep) j_in = '0;
      else if (cmd.issue_j) j_in = j_ff + ADDR_W'(1);

      rank_in = rank_ff;
      if (cmd.clr_sweep) rank_in = '0;
      else if (cmp_en_ff && outranks) rank_in = rank_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cmp_en_ff <= cmd.issue_j;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      jd_ff   <= j_ff;
      rank_ff <= rank_in;
      if (cmd.start) begin
         err_ff  <= err_now;
         zero_ff <= cfg.keep_enable && !err_now;
      end
      if (cmd.latch_v) begin
         v_ff    <= rd_data_ff;
         vmag_ff <= rd_mag;
      end
   end

   always_comb begin
      zeroed   = zero_ff && (7'(rank_ff) >= cfg.keep_count);
      kept_mag = zeroed ? '0 : CW'(vmag_ff);
      cap_x    = CW'(cfg.cap_value);
      if (kept_mag > cap_x) begin
         result = v_ff[VALUE_BITS-1] ? VALUE_BITS'(CW'(0) - cap_x) : VALUE_BITS'(cap_x);
      end else begin
         result = zeroed ? '0 : v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff <= result;
         out_pos_ff   <= 6'(i_ff);
         out_last_ff  <= stat.i_last;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_value = out_value_ff;
   assign rsp_pos   = out_pos_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_err   = out_err_ff;

endmodule

FILE: design/top_m_magnitude_keep_and_cap.sv
// Top level of the magnitude keep-and-cap block: config registers, controller, datapath.
// Depends on mkc_pkg, mkc_regs, mkc_ctrl and mkc_dpath.
//
// Samples stream in one per cycle while the input is ready and are stored in load order;
// the one marked by req_tlast closes the vector and starts emission of every stored entry
// in load order. With zeroing enabled and keep_count not above the vector length, each is
// zeroed unless its magnitude ranks among the keep_count largest (ties to the lower index);
// each is then capped to cap_value with its sign. Emission stalls while the output is held.
// With zeroing, each entry's rank comes from a sweep over all stored entries through the
// single read port of the entry memory, one entry per cycle. No new samples are taken
// until the last result of the vector is taken. Samples past MAX_ENTRIES are dropped.
// No clearing pass after reset.
module top_m_magnitude_keep_and_cap #(
   parameter int MAX_ENTRIES = mkc_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_BITS  = mkc_pkg::VALUE_BITS_DEF,
   parameter int REQ_TDATA_W = ((VALUE_BITS + 7) / 8) * 8,
   parameter int RSP_TDATA_W = ((VALUE_BITS + 6 + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mkc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mkc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mkc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // sample_value [VALUE_BITS-1:0], zero fill above
   input  logic [REQ_TDATA_W-1:0]         req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_value [VALUE_BITS-1:0], entry_position [VALUE_BITS+5:VALUE_BITS], zero fill
   output logic [RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                           rsp_tlast,
   // count_error
   output logic                           rsp_tuser
);
   import mkc_pkg::*;

   cfg_type               cfg;
   cmd_type               cmd;
   stat_type              stat;
   logic [VALUE_BITS-1:0] rsp_value;
   logic [5:0]            rsp_pos;

   mkc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mkc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mkc_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .stat       (stat),
      .req_sample (req_tdata[VALUE_BITS-1:0]),
      .rsp_value  (rsp_value),
      .rsp_pos    (rsp_pos),
      .rsp_last   (rsp_tlast),
      .rsp_err    (rsp_tuser)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_pos, rsp_value});

endmodule

FILE: design/mkc_checker.sv
// Port-level checker for the magnitude keep-and-cap block, bound to the top level.
// Depends on mkc_pkg for port widths.
module mkc_port_checks #(
   parameter int VALUE_BITS  = mkc_pkg::VALUE_BITS_DEF,
   parameter int RSP_TDATA_W = ((VALUE_BITS + 6 + 7) / 8) * 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tuser
);

   // Hold a stalled result transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Loading and emission never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready during emission");

   // A marked sample closes the vector: stop taking samples.
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input ready right after last sample");

   // Stay busy until the last result of the vector, then reopen the input.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("input reopened before end of vector");

   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("input not reopened after end of vector");

endmodule

bind top_m_magnitude_keep_and_cap mkc_port_checks #(
   .VALUE_BITS  (VALUE_BITS),
   .RSP_TDATA_W (RSP_TDATA_W)
) u_mkc_port_checks (.*);

FILE: tb/mkc_checker.sv
`timescale 1ns / 1ps
// Checker for the magnitude keep-and-cap block: tracks register writes and samples,
// forecasts every emitted entry and compares each accepted result field by field.
// Depends on mkc_pkg.
module mkc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [mkc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mkc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // sample_value [31:0]
   input  logic [31:0]                    req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_value [31:0], entry_position [37:32], zero fill [39:38]
   input  logic [39:0]                    rsp_tdata,
   input  logic                           rsp_tlast,
   // count_error
   input  logic                           rsp_tuser,
   output int                             fail_count,
   output int                             pending
);
   import mkc_pkg::*;

   localparam int DEPTH = MAX_ENTRIES_DEF;

   typedef struct packed {
      logic [31:0] value;
      logic [5:0]  position;
      logic        run_end;
      logic        count_error;
   } entry_result_type;

   logic             keep_en;
   logic [6:0]       keep_cnt;
   logic [30:0]      cap_mag;
   logic [31:0]      loaded_vals [DEPTH];
   int               load_fill;
   entry_result_type due_entries [$];

   function automatic logic [31:0] magnitude_of(input logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
   endtask

   // Forecast all entries of the closed vector: rank, zero, then cap.
   task automatic rank_and_cap_vector();
      int               n;
      int               rank;
      logic             err;
      logic             zeroing;
      logic [31:0]      v;
      logic [31:0]      m;
      logic [31:0]      r;
      logic [31:0]      cap32;
      entry_result_type e;
      n       = load_fill;
      err     = keep_en && (int'(keep_cnt) > n);
      zeroing = keep_en && !err;
      cap32   = {1'b0, cap_mag};
      for (int i = 0; i < n; i++) begin
         v = loaded_vals[i];
         m = magnitude_of(v);
         r = v;
         if (zeroing) begin
            rank = 0;
            for (int j = 0; j < n; j++) begin
               if (magnitude_of(loaded_vals[j]) > m ||
                   (magnitude_of(loaded_vals[j]) == m && j < i)) begin
                  rank++;
               end
            end
            if (rank >= int'(keep_cnt)) begin
               r = '0;
               m = '0;
            end
         end
         if (m > cap32) begin
            r = v[31] ? -cap32 : cap32;
         end
         e.value       = r;
         e.position    = 6'(i);
         e.run_end     = (i == n - 1);
         e.count_error = err;
         due_entries.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      entry_result_type want;
      if (reset) begin
         keep_en   = 1'b1;
         keep_cnt  = KEEP_COUNT_RST;
         cap_mag   = CAP_VALUE_RST;
         load_fill = 0;
         due_entries.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_KEEP_ENABLE: keep_en  = csr_pwdata[0];
               REG_KEEP_COUNT:  keep_cnt = csr_pwdata[6:0];
               REG_CAP_VALUE:   cap_mag  = csr_pwdata[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            // drop samples once the store is full; the mark still closes the vector
            if (load_fill < DEPTH) begin
               loaded_vals[load_fill] = req_tdata;
               load_fill++;
            end
            if (req_tlast) begin
               rank_and_cap_vector();
               load_fill = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_entries.size() == 0) begin
               report_mismatch("unexpected result, value", rsp_tdata[31:0], '0);
            end else begin
               want = due_entries.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  report_mismatch("result_value", rsp_tdata[31:0], want.value);
               end
               if (rsp_tdata[37:32] !== want.position) begin
                  report_mismatch("entry_position", 32'(rsp_tdata[37:32]),
                                  32'(want.position));
               end
               if (rsp_tlast !== want.run_end) begin
                  report_mismatch("run_end", 32'(rsp_tlast), 32'(want.run_end));
               end
               if (rsp_tuser !== want.count_error) begin
                  report_mismatch("count_error", 32'(rsp_tuser), 32'(want.count_error));
               end
            end
         end
      end
      pending = due_entries.size();
   end

endmodule

FILE: tb/tb_top_m_magnitude_keep_and_cap.sv
`timescale 1ns / 1ps
// Testbench top for the magnitude keep-and-cap block: clock, reset, register writes,
// sample vectors with random gaps and output stalls, and the final verdict.
// Depends on mkc_pkg, top_m_magnitude_keep_and_cap and mkc_checker.
module tb_top_m_magnitude_keep_and_cap;
   import mkc_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // sample_value [31:0]
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;   // result_value [31:0], entry_position [37:32]
   logic                  rsp_tlast;
   logic                  rsp_tuser;   // count_error

   int fail_count;
   int pending;
   int send_idle;
   int recv_stall;
   int hold_asks;
   int hold_seen;
   int hold_len;

   top_m_magnitude_keep_and_cap uut (.*);

   mkc_checker chk (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .fail_count, .pending
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Result side: random stalls, or a long hold-off counted down here.
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_len  = 500;
      end
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   initial begin
      #8_000_000;
      $display("** top_m_magnitude_keep_and_cap: FAILED **");
      $finish;
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Call at a falling edge; returns at the falling edge after the transaction.
   task automatic send_item(input logic [31:0] v, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_sample();
      logic [31:0] pick;
      case ($urandom_range(7))
         3: pick = 32'(int'($urandom_range(8)) - 4);
         4: begin
            pick = $urandom_range(32'h0004_0000);
            if ($urandom_range(1)) pick = -pick;
         end
         5: begin
            case ($urandom_range(3))
               0: pick = 32'h8000_0000;
               1: pick = 32'h7FFF_FFFF;
               2: pick = 32'h8000_0001;
               default: pick = '0;
            endcase
         end
         default: pick = $urandom;
      endcase
      return pick;
   endfunction

   function automatic logic [30:0] rand_cap();
      case ($urandom_range(3))
         0: return 31'($urandom);
         1: return 31'($urandom_range(32'h0004_0000));
         2: return 31'h7FFF_FFFF;
         default: return 31'($urandom_range(16));
      endcase
   endfunction

   task automatic send_vector(input int len);
      for (int k = 0; k < len; k++) send_item(rand_sample(), k == len - 1);
   endtask

   // Wait out all results, then let the block settle before touching registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      int sent;
      int len;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      send_idle   = 0;
      recv_stall  = 0;
      hold_asks   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: count of 64 exceeds any short vector, full-scale cap.
      send_item(32'h8000_0000, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h0000_0000, 1'b1);
      drain();

      // Keep three with ties between equal magnitudes, cap at 3.0.
      csr_write(REG_KEEP_COUNT, 32'd3);
      csr_write(REG_CAP_VALUE, 32'h0003_0000);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFB, 1'b0);
      send_item(32'h0000_0005, 1'b0);
      send_item(32'h0001_0000, 1'b0);
      send_item(32'hFFFF_0000, 1'b1);
      drain();

      // Keep nothing: every entry goes to zero.
      csr_write(REG_KEEP_COUNT, 32'd0);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b1);
      drain();

      // Zeroing off, zero cap: only the cap applies and no count error.
      csr_write(REG_KEEP_ENABLE, 32'd0);
      csr_write(REG_CAP_VALUE, 32'd0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'h1234_5678, 1'b1);
      drain();

      // Four equal magnitudes, keep two: the lower indexes win.
      csr_write(REG_KEEP_ENABLE, 32'd1);
      csr_write(REG_KEEP_COUNT, 32'd2);
      csr_write(REG_CAP_VALUE, 32'h7FFF_FFFF);
      send_item(32'h0000_0007, 1'b0);
      send_item(32'hFFFF_FFF9, 1'b0);
      send_item(32'h0000_0007, 1'b0);
      send_item(32'hFFFF_FFF9, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 75; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 75; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         if (p == 0) begin
            csr_write(REG_KEEP_ENABLE, 32'd1);
            csr_write(REG_KEEP_COUNT, 32'd64);
            csr_write(REG_CAP_VALUE, 32'h7FFF_FFFF);
         end else if (p == 1) begin
            csr_write(REG_KEEP_ENABLE, 32'd1);
            csr_write(REG_KEEP_COUNT, 32'd0);
            csr_write(REG_CAP_VALUE, 32'd0);
         end else begin
            csr_write(REG_KEEP_ENABLE, (p == 3 || p == 6) ? 32'd0 : 32'd1);
            csr_write(REG_KEEP_COUNT,
                      ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(8));
            csr_write(REG_CAP_VALUE, 32'(rand_cap()));
         end
         // Hold results back while samples keep coming, so the input backs up.
         if (p == 0) hold_asks++;
         sent = 0;
         if (p == 2) begin
            send_vector(64);
            sent += 64;
         end
         if (p == 5) begin
            // overfill the store; the extra samples are dropped
            send_vector(67);
            sent += 67;
         end
         while (sent < 18) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_vector(len);
            sent += len;
         end
         drain();
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** top_m_magnitude_keep_and_cap: PASSED **");
      end else begin
         $display("** top_m_magnitude_keep_and_cap: FAILED **");
      end
      $finish;
   end

endmodule
